### hdl/hbw_pkg.sv
package hbw_pkg;

    localparam int CHANNELS  = 8;
    localparam int MAX_OUT   = 8;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int EV_CNT_W  = $clog2(MAX_OUT + 1);
    localparam int WORD_W    = 32;
    localparam int LIMIT_W   = 30;
    localparam int COUNT_W   = 16;
    localparam int TAG_W     = 3;

    localparam logic [1:0] CMD_REG   = 2'd0;
    localparam logic [1:0] CMD_BEAT  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_RECOV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_WARN = 2'd1;
    localparam logic [1:0] ST_CRIT = 2'd2;
    localparam logic [1:0] ST_DEAD = 2'd3;

    localparam logic [2:0] EV_REG   = 3'd0;
    localparam logic [2:0] EV_FULL  = 3'd1;
    localparam logic [2:0] EV_WARN  = 3'd2;
    localparam logic [2:0] EV_CRIT  = 3'd3;
    localparam logic [2:0] EV_DEAD  = 3'd4;
    localparam logic [2:0] EV_RECOV = 3'd5;

    typedef struct packed {
        logic [2:0]         ev;
        logic [COUNT_W-1:0] recs;
        logic [COUNT_W-1:0] fails;
        logic [WORD_W-1:0]  elapsed;
        logic [1:0]         status;
        logic [TAG_W-1:0]   tag;
        logic [2:0]         index;
        logic               req;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic              borrow;
    } alu_rsp_t;

endpackage

### hdl/hbw_alu.sv
module hbw_alu (
    input  hbw_pkg::alu_req_t req,
    output hbw_pkg::alu_rsp_t rsp
);

    logic [hbw_pkg::WORD_W:0] full_sum;
    logic [hbw_pkg::WORD_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign full_sum = {1'b0, req.a} + {1'b0, b_op} + {{hbw_pkg::WORD_W{1'b0}}, req.sub};
    assign rsp.sum = full_sum[hbw_pkg::WORD_W-1:0];
    assign rsp.borrow = req.sub & ~full_sum[hbw_pkg::WORD_W];

endmodule

### hdl/heartbeat_escalation_watchdog.sv
// channel  | direction | contents
// s_       | in        | tuser: command; tdata: now, tag, timeout, recovery flags
// m_       | out       | tuser: event; tdata: request, channel, status, counts; tlast
// Heartbeat: one channel per cycle unless a held event stalls it. Health check: per
// channel, elapsed time vs. timeout; past it, vs. double and triple the timeout,
// each sum and compare on the shared 32-bit add/subtract unit.
// s_tready is high only between requests; a held output stalls the walk when a
// second event waits. Reset clears control state only; channel entries are
// meaningless until registered.
module heartbeat_escalation_watchdog (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // now_ms, unit_tag, tmo_limit, has_recovery,
                                  // target_index, recovery_ok, zero fill
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // recovery_request, slot_index, slot_tag, new_status,
                                  // elapsed_ms, fail_total, recover_total, zero fill
    output logic [2:0]  m_tuser,  // event_res
    output logic        m_tlast   // final_event
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEAT  = 4'd1;
    localparam logic [3:0] S_RECOV = 4'd2;
    localparam logic [3:0] S_ELAP  = 4'd3;
    localparam logic [3:0] S_CMP1  = 4'd4;
    localparam logic [3:0] S_DBL   = 4'd5;
    localparam logic [3:0] S_CMP2  = 4'd6;
    localparam logic [3:0] S_TRP   = 4'd7;
    localparam logic [3:0] S_CMP3  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;

    logic [3:0]                    state_reg;
    logic [hbw_pkg::CNT_W-1:0]     idx_reg;
    logic [hbw_pkg::CNT_W-1:0]     used_reg;
    logic [hbw_pkg::EV_CNT_W-1:0]  ev_cnt_reg;
    logic [hbw_pkg::WORD_W-1:0]    now_reg;
    logic [hbw_pkg::TAG_W-1:0]     tag_reg;
    logic [2:0]                    tgt_reg;
    logic                          okr_reg;
    logic [hbw_pkg::WORD_W-1:0]    el_reg;
    logic [hbw_pkg::WORD_W-1:0]    acc_reg;
    logic                          gt2_reg;
    logic                          gt3_reg;
    logic                          pend_valid_reg;
    hbw_pkg::res_t                 pend_reg;
    logic                          m_valid_reg;
    hbw_pkg::res_t                 m_res_reg;
    logic                          m_last_reg;

    logic [hbw_pkg::TAG_W-1:0]     kind_mem   [hbw_pkg::CHANNELS];
    logic [hbw_pkg::LIMIT_W-1:0]   limit_mem  [hbw_pkg::CHANNELS];
    logic [hbw_pkg::WORD_W-1:0]    beat_mem   [hbw_pkg::CHANNELS];
    logic [1:0]                    status_mem [hbw_pkg::CHANNELS];
    logic [hbw_pkg::COUNT_W-1:0]   fail_mem   [hbw_pkg::CHANNELS];
    logic [hbw_pkg::COUNT_W-1:0]   recs_mem   [hbw_pkg::CHANNELS];
    logic                          canrec_mem [hbw_pkg::CHANNELS];

    logic                          s_acc;
    logic                          out_free;
    logic                          can_push;
    logic                          in_range;
    logic                          hb_hit;
    logic                          rec_go;
    logic                          ev_room;
    logic                          move_pend;
    logic [hbw_pkg::IDX_W-1:0]     ix;
    logic [hbw_pkg::IDX_W-1:0]     tgt_ix;
    logic [hbw_pkg::IDX_W-1:0]     new_ix;
    logic [hbw_pkg::WORD_W-1:0]    lim_ext;
    logic [hbw_pkg::COUNT_W-1:0]   fail_inc;
    logic [hbw_pkg::COUNT_W-1:0]   rec_inc;
    logic [1:0]                    grade;
    logic                          new_valid;
    hbw_pkg::res_t                 new_res;
    hbw_pkg::alu_req_t             alu_req;
    hbw_pkg::alu_rsp_t             alu_rsp;

    hbw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign can_push = !pend_valid_reg || out_free;
    assign ix       = idx_reg[hbw_pkg::IDX_W-1:0];
    assign tgt_ix   = hbw_pkg::IDX_W'(tgt_reg);
    assign new_ix   = used_reg[hbw_pkg::IDX_W-1:0];
    assign in_range = idx_reg < used_reg;
    assign lim_ext  = {{(hbw_pkg::WORD_W - hbw_pkg::LIMIT_W){1'b0}}, limit_mem[ix]};
    assign hb_hit   = in_range && (kind_mem[ix] == tag_reg);
    assign rec_go   = (hbw_pkg::CNT_W'(tgt_reg) < used_reg) && canrec_mem[tgt_ix]
                      && (status_mem[tgt_ix] == hbw_pkg::ST_CRIT) && okr_reg;
    assign ev_room  = ev_cnt_reg < hbw_pkg::EV_CNT_W'(hbw_pkg::MAX_OUT);
    assign fail_inc = (fail_mem[ix] == '1) ? fail_mem[ix] : fail_mem[ix] + 1'b1;
    assign rec_inc  = (recs_mem[tgt_ix] == '1) ? recs_mem[tgt_ix] : recs_mem[tgt_ix] + 1'b1;
    assign grade    = gt3_reg ? hbw_pkg::ST_DEAD :
                      gt2_reg ? hbw_pkg::ST_CRIT : hbw_pkg::ST_WARN;
    assign move_pend = pend_valid_reg &&
                       (new_valid || (state_reg == S_FLUSH && out_free));

    always_comb begin
        alu_req = '0;
        unique case (state_reg) inside
            S_ELAP: begin
                alu_req.a   = now_reg;
                alu_req.b   = beat_mem[ix];
                alu_req.sub = 1'b1;
            end
            S_CMP1: begin
                alu_req.a   = lim_ext;
                alu_req.b   = el_reg;
                alu_req.sub = 1'b1;
            end
            S_DBL, S_TRP: begin
                alu_req.a   = acc_reg;
                alu_req.b   = lim_ext;
                alu_req.sub = 1'b0;
            end
            S_CMP2, S_CMP3: begin
                alu_req.a   = acc_reg;
                alu_req.b   = el_reg;
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        new_valid = 1'b0;
        new_res   = '0;
        unique case (state_reg)
            S_IDLE: begin
                new_valid = s_acc && (s_tuser == hbw_pkg::CMD_REG);
                if (used_reg >= hbw_pkg::CNT_W'(hbw_pkg::CHANNELS)) begin
                    new_res.ev = hbw_pkg::EV_FULL;
                end else begin
                    new_res.ev    = hbw_pkg::EV_REG;
                    new_res.index = 3'(used_reg);
                    new_res.tag   = s_tdata[34:32];
                end
            end
            S_BEAT: begin
                new_valid     = can_push && hb_hit && ev_room
                                && (status_mem[ix] != hbw_pkg::ST_OK);
                new_res.ev    = hbw_pkg::EV_RECOV;
                new_res.index = 3'(ix);
                new_res.tag   = tag_reg;
                new_res.recs  = recs_mem[ix];
            end
            S_RECOV: begin
                new_valid     = can_push && rec_go && ev_room;
                new_res.ev    = hbw_pkg::EV_RECOV;
                new_res.index = tgt_reg;
                new_res.tag   = kind_mem[tgt_ix];
                new_res.recs  = rec_inc;
            end
            S_UPD: begin
                new_valid       = can_push && ev_room && (status_mem[ix] != grade);
                new_res.ev      = (grade == hbw_pkg::ST_WARN) ? hbw_pkg::EV_WARN :
                                  (grade == hbw_pkg::ST_CRIT) ? hbw_pkg::EV_CRIT :
                                  hbw_pkg::EV_DEAD;
                new_res.req     = (grade == hbw_pkg::ST_CRIT) && canrec_mem[ix];
                new_res.index   = 3'(ix);
                new_res.tag     = kind_mem[ix];
                new_res.status  = grade;
                new_res.elapsed = el_reg;
                new_res.fails   = fail_inc;
                new_res.recs    = recs_mem[ix];
            end
            default: begin
                new_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            used_reg       <= '0;
            ev_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (move_pend) begin
                m_res_reg   <= pend_reg;
                m_last_reg  <= (state_reg == S_FLUSH);
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (new_valid) begin
                pend_reg       <= new_res;
                pend_valid_reg <= 1'b1;
            end else if (move_pend) begin
                pend_valid_reg <= 1'b0;
            end

            if (s_acc) begin
                ev_cnt_reg <= hbw_pkg::EV_CNT_W'(new_valid);
            end else if (new_valid) begin
                ev_cnt_reg <= ev_cnt_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        now_reg <= s_tdata[31:0];
                        tag_reg <= s_tdata[34:32];
                        tgt_reg <= s_tdata[68:66];
                        okr_reg <= s_tdata[69];
                        idx_reg <= '0;
                        unique case (s_tuser)
                            hbw_pkg::CMD_REG: begin
                                if (used_reg < hbw_pkg::CNT_W'(hbw_pkg::CHANNELS)) begin
                                    kind_mem[new_ix]   <= s_tdata[34:32];
                                    limit_mem[new_ix]  <= s_tdata[64:35];
                                    beat_mem[new_ix]   <= s_tdata[31:0];
                                    status_mem[new_ix] <= hbw_pkg::ST_OK;
                                    fail_mem[new_ix]   <= '0;
                                    recs_mem[new_ix]   <= '0;
                                    canrec_mem[new_ix] <= s_tdata[65];
                                    used_reg           <= used_reg + 1'b1;
                                end
                                state_reg <= S_FLUSH;
                            end
                            hbw_pkg::CMD_BEAT:  state_reg <= S_BEAT;
                            hbw_pkg::CMD_CHECK: state_reg <= S_ELAP;
                            hbw_pkg::CMD_RECOV: state_reg <= S_RECOV;
                            default:            state_reg <= S_FLUSH;
                        endcase
                    end
                end
                S_BEAT: begin
                    if (can_push) begin
                        if (!in_range) begin
                            state_reg <= S_FLUSH;
                        end else if (hb_hit) begin
                            beat_mem[ix]   <= now_reg;
                            status_mem[ix] <= hbw_pkg::ST_OK;
                            if (status_mem[ix] != hbw_pkg::ST_OK) begin
                                fail_mem[ix] <= '0;
                            end
                            state_reg <= S_FLUSH;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_RECOV: begin
                    if (can_push) begin
                        if (rec_go) begin
                            recs_mem[tgt_ix]   <= rec_inc;
                            beat_mem[tgt_ix]   <= now_reg;
                            status_mem[tgt_ix] <= hbw_pkg::ST_OK;
                            fail_mem[tgt_ix]   <= '0;
                        end
                        state_reg <= S_FLUSH;
                    end
                end
                S_ELAP: begin
                    if (!in_range) begin
                        state_reg <= S_FLUSH;
                    end else begin
                        el_reg    <= alu_rsp.sum;
                        state_reg <= S_CMP1;
                    end
                end
                S_CMP1: begin
                    if (alu_rsp.borrow) begin
                        acc_reg   <= lim_ext;
                        state_reg <= S_DBL;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ELAP;
                    end
                end
                S_DBL: begin
                    acc_reg   <= alu_rsp.sum;
                    state_reg <= S_CMP2;
                end
                S_CMP2: begin
                    gt2_reg   <= alu_rsp.borrow;
                    state_reg <= S_TRP;
                end
                S_TRP: begin
                    acc_reg   <= alu_rsp.sum;
                    state_reg <= S_CMP3;
                end
                S_CMP3: begin
                    gt3_reg   <= alu_rsp.borrow;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (can_push) begin
                        fail_mem[ix]   <= fail_inc;
                        status_mem[ix] <= grade;
                        idx_reg        <= idx_reg + 1'b1;
                        state_reg      <= S_ELAP;
                    end
                end
                S_FLUSH: begin
                    if (!pend_valid_reg || out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.ev;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'b0, m_res_reg.recs, m_res_reg.fails, m_res_reg.elapsed,
                       m_res_reg.status, m_res_reg.tag, m_res_reg.index, m_res_reg.req};

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("request accepted while an event is still pending");

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= hbw_pkg::CHANNELS)
        else $error("channel count beyond table size");

    a_register_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == hbw_pkg::CMD_REG
         && used_reg < hbw_pkg::CNT_W'(hbw_pkg::CHANNELS))
        |=> used_reg == $past(used_reg) + (hbw_pkg::CNT_W)'(1))
        else $error("registration did not add a channel");

    a_flush_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && pend_valid_reg && out_free) |=> (m_tvalid && m_tlast))
        else $error("last event of a request not marked");

    a_event_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_cnt_reg <= hbw_pkg::MAX_OUT)
        else $error("event count beyond limit");

endmodule
